// ===== rtl/lrfe_pkg.sv =====
// Shared types, constants and functions for the log record frame encoder.
// No dependencies; the front, queue, back and top-level files import this package.
package lrfe_pkg;

  // Frame layout
  localparam int unsigned LEN_BYTES     = 4;
  localparam int unsigned PAYLOAD_BYTES = 25;
  localparam int unsigned CRC_BYTES     = 4;
  localparam int unsigned FRAME_BYTES   = LEN_BYTES + PAYLOAD_BYTES + CRC_BYTES;
  localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int unsigned IDX_W         = $clog2(FRAME_BYTES);

  // Payload type byte and CRC-32 (reflected) constants
  localparam logic [7:0]  TYPE_BYTE = 8'h04;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef logic [PAYLOAD_W-1:0] payload_t;

  // One payload word plus its valid flag, front/queue/back hand-off
  typedef struct packed {
    logic     valid;
    payload_t data;
  } pl_word_t;

  // Pack record fields into payload order; byte 0 sits in bits [7:0]
  function automatic payload_t pack_payload(
    input logic [63:0] timestamp_ns,
    input logic [15:0] tag_id,
    input logic [31:0] sequence_number,
    input logic [31:0] event_code,
    input logic [31:0] temperature_tenths,
    input logic [15:0] severity_level
  );
    return {severity_level, temperature_tenths, event_code, sequence_number,
            TYPE_BYTE, tag_id, timestamp_ns};
  endfunction

  // Reflected CRC-32 update by one byte, bit at a time
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/lrfe_if.sv =====
// Channel interfaces for the log record frame encoder: record in, frame byte out.
// Depends on nothing; valid/ready handshake, a word moves when both are high.
interface lrfe_in_if;
  logic               valid;
  logic               ready;
  logic [63:0]        timestamp_ns;
  logic [15:0]        tag_id;
  logic [31:0]        sequence_number;
  logic [31:0]        event_code;
  logic signed [31:0] temperature_tenths;
  logic [15:0]        severity_level;

  modport source(output valid, output timestamp_ns, output tag_id,
                 output sequence_number, output event_code,
                 output temperature_tenths, output severity_level, input ready);
  modport sink(input valid, input timestamp_ns, input tag_id,
               input sequence_number, input event_code,
               input temperature_tenths, input severity_level, output ready);
endinterface

interface lrfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source(output valid, output frame_byte, output last_byte, input ready);
  modport sink(input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== rtl/lrfe_front.sv =====
// Front end: accepts record words and packs them into a payload word.
// Depends on lrfe_pkg and lrfe_in_if; feeds lrfe_queue.
module lrfe_front (
  input  logic                clk,
  input  logic                rst_n,
  lrfe_in_if.sink             in_rec,
  output lrfe_pkg::pl_word_t  push,
  input  logic                push_ready
);
  import lrfe_pkg::*;

  logic     stg_valid_r;
  payload_t stg_data_r;

  // Staging register empties whenever the queue takes it
  assign in_rec.ready = !stg_valid_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_rec.ready) begin
      stg_valid_r <= in_rec.valid;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_rec.valid && in_rec.ready) begin
      stg_data_r <= pack_payload(in_rec.timestamp_ns, in_rec.tag_id,
                                 in_rec.sequence_number, in_rec.event_code,
                                 in_rec.temperature_tenths, in_rec.severity_level);
    end
  end

  assign push.valid = stg_valid_r;
  assign push.data  = stg_data_r;

endmodule

// ===== rtl/lrfe_queue.sv =====
// Short FIFO of payload words between the front and back ends.
// Depends on lrfe_pkg.
module lrfe_queue #(
  parameter int unsigned DEPTH = lrfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lrfe_pkg::pl_word_t  push,
  output logic                push_ready,
  output lrfe_pkg::pl_word_t  pop,
  input  logic                pop_ready
);
  import lrfe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  payload_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop.valid  = (count_r != '0);
  assign pop.data   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

endmodule

// ===== rtl/lrfe_back.sv =====
// Back end: serializes length, payload and CRC-32 bytes of one frame.
// Depends on lrfe_pkg and lrfe_out_if; drains lrfe_queue.
module lrfe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lrfe_pkg::pl_word_t  pop,
  output logic                pop_ready,
  lrfe_out_if.source          out_frame
);
  import lrfe_pkg::*;

  localparam logic [IDX_W-1:0] PAY_START = IDX_W'(LEN_BYTES);
  localparam logic [IDX_W-1:0] CRC_START = IDX_W'(LEN_BYTES + PAYLOAD_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_BYTES - 1);

  logic             busy_r;
  logic [IDX_W-1:0] idx_r;
  payload_t         pl_r;
  logic [31:0]      crc_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             advance;
  logic             emit;
  logic             at_last;
  logic             in_len;
  logic             in_pay;
  logic [7:0]       byte_nxt;

  // Output register moves when empty or taken
  assign advance   = !out_valid_r || out_frame.ready;
  assign emit      = advance && busy_r;
  assign at_last   = (idx_r == LAST_IDX);
  assign pop_ready = advance && (!busy_r || at_last);

  assign in_len = (idx_r < PAY_START);
  assign in_pay = (idx_r < CRC_START);

  // Byte for the current frame position
  always_comb begin
    if (in_len) begin
      byte_nxt = (idx_r == '0) ? 8'(PAYLOAD_BYTES) : 8'h00;
    end else if (in_pay) begin
      byte_nxt = pl_r[7:0];
    end else begin
      byte_nxt = ~crc_r[7:0];
    end
  end

  // Frame sequencer: position, payload shifter and running CRC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop.valid && pop_ready) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (emit) begin
      busy_r <= !at_last;
      idx_r  <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop.valid && pop_ready) begin
      pl_r  <= pop.data;
      crc_r <= CRC_INIT;
    end else if (emit && !in_len) begin
      if (in_pay) begin
        pl_r  <= pl_r >> 8;
        crc_r <= crc_byte(crc_r, pl_r[7:0]);
      end else begin
        crc_r <= crc_r >> 8;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_nxt;
      out_last_r <= at_last;
    end
  end

  assign out_frame.valid      = out_valid_r;
  assign out_frame.frame_byte = out_byte_r;
  assign out_frame.last_byte  = out_last_r;

endmodule

// ===== rtl/log_record_frame_encoder.sv =====
// Top level of the log record frame encoder: front end, queue, back end.
// Depends on lrfe_pkg, lrfe_if, lrfe_front, lrfe_queue and lrfe_back.
//
// Each record word on in_rec becomes a 33-byte frame on out_frame, one byte
// per word: a 4-byte little-endian length (25), the 25-byte payload
// (timestamp, tag, type byte 4, sequence, code, temperature, level, all
// little-endian), then the little-endian reflected CRC-32 of the payload;
// last_byte marks the final CRC byte. The sustained record rate is set by
// the byte-wide output register of the back end, which emits one byte per
// cycle while out_frame.ready is high. Records are taken while an earlier
// frame is still streaming: a staging register and a QUEUE_DEPTH-entry
// queue hold them. A record passes the staging register, the queue and the
// back end's frame sequencer on its way to the output register.
module log_record_frame_encoder #(
  parameter int unsigned QUEUE_DEPTH = lrfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lrfe_in_if.sink     in_rec,
  lrfe_out_if.source  out_frame
);
  import lrfe_pkg::*;

  pl_word_t push;
  pl_word_t pop;
  logic     push_ready;
  logic     pop_ready;

  // Accept and pack records
  lrfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rec     (in_rec),
    .push       (push),
    .push_ready (push_ready)
  );

  // Decouple front and back
  lrfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  // Serialize frames
  lrfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_ready (pop_ready),
    .out_frame (out_frame)
  );

endmodule
